[sv/cqre_pkg.sv]
// Shared types, codes and field layout for the query retry engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cqre_pkg;

  // Default job slot count
  localparam int JOBS_DEF = 32;

  // Field widths
  localparam int JOB_W   = 5;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 13;
  localparam int KIND_W  = 8;
  localparam int CHAL_W  = 32;
  localparam int PH_W    = 3;
  localparam int ATT_W   = 4;
  localparam int CNT_W   = 6;
  localparam int TMO_W   = 16;
  localparam int LIMIT_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Stream packing
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;

  // Input item kinds
  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_PACKET = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  // Result kinds
  typedef enum logic [1:0] {
    RK_SEND    = 2'd0,
    RK_STATUS  = 2'd1,
    RK_SUMMARY = 2'd2
  } result_kind_t;

  // Job phases (3-bit codes, 5..7 never stored)
  localparam logic [PH_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PH_W-1:0] PH_WAIT_CHAL = 3'd1;
  localparam logic [PH_W-1:0] PH_GOT_CHAL  = 3'd2;
  localparam logic [PH_W-1:0] PH_WAIT_LIST = 3'd3;
  localparam logic [PH_W-1:0] PH_DONE      = 3'd4;

  // Request kinds
  localparam logic RQ_CHALLENGE = 1'b0;
  localparam logic RQ_LIST      = 1'b1;

  // Packet type bytes and filler
  localparam logic [KIND_W-1:0] PKT_CHALLENGE = 8'h41;
  localparam logic [KIND_W-1:0] PKT_LIST      = 8'h44;
  localparam logic [CHAL_W-1:0] FILLER_CHAL   = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0]  LEN_CHAL_MIN  = 13'd9;
  localparam logic [LEN_W-1:0]  LEN_LIST_MIN  = 13'd6;
  localparam logic [LEN_W-1:0]  LEN_HDR       = 13'd4;
  localparam logic [ATT_W-1:0]  ATT_MAX       = 4'd15;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_LIMIT   = 2'd2;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST      = 16'd1000;
  localparam logic [ATT_W-1:0]   MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [LIMIT_W-1:0] SEND_LIMIT_RST   = 6'd32;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUM
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;  // capture accepted item
    logic step;  // commit the current job step
    logic sum;   // emit tick summary
  } cqre_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;
    logic need_out;
    logic scan_done;
    logic is_tick;
  } cqre_sts_t;

endpackage
`default_nettype wire

[sv/cqre_ctrl.sv]
// Sequencer for the query retry engine: accept, per-job steps, summary.
// Depends on cqre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cqre_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire cqre_pkg::req_type_t in_type,
  input  wire cqre_pkg::cqre_sts_t sts,
  output cqre_pkg::cqre_cmd_t      cmd
);
  import cqre_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_type != REQ_NONE) state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.need_out || sts.out_free) begin
          cmd.step = 1'b1;
          if (!sts.is_tick) begin
            state_nxt = ST_IDLE;
          end else if (sts.scan_done) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (sts.out_free) begin
          cmd.sum   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/cqre_dp.sv]
// Datapath: job tables, per-job step logic, config registers, result register.
// Depends on cqre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cqre_dp #(
  parameter int JOBS = cqre_pkg::JOBS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cqre_pkg::cqre_cmd_t                cmd,
  output cqre_pkg::cqre_sts_t                     sts,
  input  wire cqre_pkg::req_type_t                in_type,
  input  wire logic [cqre_pkg::JOB_W-1:0]         in_job,
  input  wire logic [cqre_pkg::TIME_W-1:0]        in_now,
  input  wire logic [cqre_pkg::LEN_W-1:0]         in_len,
  input  wire logic [cqre_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [cqre_pkg::CHAL_W-1:0]        in_chal,
  input  wire logic                               cfg_we,
  input  wire logic [cqre_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [cqre_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output cqre_pkg::result_kind_t                  out_kind,
  output logic [cqre_pkg::JOB_W-1:0]              out_job,
  output logic                                    out_rkind,
  output logic [cqre_pkg::CHAL_W-1:0]             out_chal,
  output logic [cqre_pkg::PH_W-1:0]               out_phase,
  output logic                                    out_succ,
  output logic [cqre_pkg::CNT_W-1:0]              out_running,
  output logic                                    out_last
);
  import cqre_pkg::*;

  localparam int IDX_W = (JOBS > 1) ? $clog2(JOBS) : 1;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [ATT_W-1:0] att;
    logic             succ;
  } job_st_t;

  // config
  logic [TMO_W-1:0]   timeout_r;
  logic [ATT_W-1:0]   max_att_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      max_att_r <= MAX_ATTEMPTS_RST;
      limit_r   <= SEND_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TIMEOUT:      timeout_r <= cfg_wdata;
        CFG_MAX_ATTEMPTS: max_att_r <= cfg_wdata[ATT_W-1:0];
        CFG_SEND_LIMIT:   limit_r   <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // latched item
  req_type_t          type_r;
  logic [JOB_W-1:0]   job_r;
  logic [TIME_W-1:0]  now_r;
  logic [LEN_W-1:0]   len_r;
  logic [KIND_W-1:0]  kind_r;
  logic [CHAL_W-1:0]  chal_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_type;
      job_r  <= in_job;
      now_r  <= in_now;
      len_r  <= in_len;
      kind_r <= in_kind;
      chal_r <= in_chal;
    end
  end

  // scan state
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] running_r, running_nxt;
  logic [CNT_W-1:0] sent_r, sent_nxt;

  // tables
  job_st_t           st_mem   [JOBS];
  logic [TIME_W-1:0] time_mem [JOBS];
  logic [CHAL_W-1:0] chal_mem [JOBS];
  logic [JOBS-1:0]   valid_r;

  job_st_t           st_rd_r;
  logic [TIME_W-1:0] time_rd_r;
  logic [CHAL_W-1:0] chal_rd_r;
  logic              vld_rd_r;

  logic [IDX_W-1:0] rd_addr;
  logic             in_job_ok;
  logic             job_ok;

  assign in_job_ok = (7'(in_job) < 7'(JOBS));
  assign job_ok    = (7'(job_r) < 7'(JOBS));

  // step logic
  logic [PH_W-1:0]  ph_cur;
  logic [ATT_W-1:0] att_cur;
  logic             succ_cur;
  logic [ATT_W-1:0] fail_att;
  logic             fail_done;
  logic             timed_out;
  logic             last_job;
  logic             send;
  job_st_t          st_new;
  logic             wr_st, wr_time, wr_chal;
  logic             need_out;
  logic             scan_done;
  result_kind_t     res_kind;
  logic             res_rkind;
  logic [CHAL_W-1:0] res_chal;
  logic [PH_W-1:0]  res_phase;
  logic             res_succ;
  logic             res_last;

  assign ph_cur    = vld_rd_r ? st_rd_r.phase : PH_DONE;
  assign att_cur   = vld_rd_r ? st_rd_r.att   : '0;
  assign succ_cur  = vld_rd_r ? st_rd_r.succ  : 1'b0;
  assign fail_att  = (att_cur == ATT_MAX) ? ATT_MAX : att_cur + ATT_W'(1);
  assign fail_done = (fail_att >= max_att_r);
  assign timed_out = ((now_r - time_rd_r) > TIME_W'(timeout_r));
  assign last_job  = (idx_r == IDX_W'(JOBS - 1));

  always_comb begin
    st_new    = '{phase: ph_cur, att: att_cur, succ: succ_cur};
    wr_st     = 1'b0;
    wr_time   = 1'b0;
    wr_chal   = 1'b0;
    send      = 1'b0;
    need_out  = 1'b0;
    res_kind  = RK_STATUS;
    res_rkind = RQ_CHALLENGE;
    res_chal  = '0;
    res_last  = 1'b1;
    case (type_r)
      REQ_TICK: begin
        case (ph_cur)
          PH_IDLE: begin
            st_new.phase = PH_WAIT_CHAL;
            send         = 1'b1;
            res_rkind    = RQ_CHALLENGE;
            res_chal     = FILLER_CHAL;
          end
          PH_GOT_CHAL: begin
            st_new.phase = PH_WAIT_LIST;
            send         = 1'b1;
            res_rkind    = RQ_LIST;
            res_chal     = chal_rd_r;
          end
          PH_WAIT_CHAL, PH_WAIT_LIST: begin
            if (timed_out) begin
              wr_st        = 1'b1;
              st_new.att   = fail_att;
              st_new.phase = fail_done ? PH_DONE :
                             (ph_cur == PH_WAIT_CHAL) ? PH_IDLE : PH_GOT_CHAL;
            end
          end
          default: ;
        endcase
        if (send) begin
          wr_st    = 1'b1;
          wr_time  = 1'b1;
          need_out = 1'b1;
          res_kind = RK_SEND;
          res_last = 1'b0;
        end
      end
      REQ_START: begin
        need_out = 1'b1;
        if (job_ok) begin
          wr_st  = 1'b1;
          st_new = '{phase: PH_IDLE, att: '0, succ: 1'b0};
        end
      end
      REQ_PACKET: begin
        need_out = 1'b1;
        if (job_ok && (len_r != '0)) begin
          case (ph_cur)
            PH_WAIT_CHAL: begin
              wr_st = 1'b1;
              if ((len_r >= LEN_CHAL_MIN) && (kind_r == PKT_CHALLENGE)) begin
                wr_chal      = 1'b1;
                st_new.phase = PH_GOT_CHAL;
                st_new.att   = '0;
              end else if ((len_r > LEN_HDR) && (kind_r == PKT_LIST)) begin
                st_new.phase = PH_DONE;
                st_new.succ  = 1'b1;
              end else begin
                st_new.att   = fail_att;
                st_new.phase = fail_done ? PH_DONE : PH_IDLE;
              end
            end
            PH_WAIT_LIST: begin
              wr_st = 1'b1;
              if ((len_r >= LEN_LIST_MIN) && (kind_r == PKT_LIST)) begin
                st_new.phase = PH_DONE;
                st_new.succ  = 1'b1;
              end else begin
                st_new.att   = fail_att;
                st_new.phase = fail_done ? PH_DONE : PH_GOT_CHAL;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res_phase = job_ok || (type_r == REQ_TICK) ? st_new.phase : PH_DONE;
    res_succ  = job_ok || (type_r == REQ_TICK) ? st_new.succ  : 1'b0;
  end

  assign sent_nxt    = sent_r + CNT_W'(send);
  assign running_nxt = running_r + CNT_W'(ph_cur != PH_DONE);
  assign scan_done   = (sent_nxt >= limit_r) || last_job;

  // read address: new item, next scanned job, or hold
  always_comb begin
    if (cmd.load) begin
      rd_addr = ((in_type == REQ_TICK) || !in_job_ok) ? '0 : IDX_W'(in_job);
    end else if (cmd.step && (type_r == REQ_TICK) && !scan_done) begin
      rd_addr = idx_r + IDX_W'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = ((in_type == REQ_TICK) || !in_job_ok) ? '0 : IDX_W'(in_job);
    end else if (cmd.step && (type_r == REQ_TICK) && !scan_done) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      running_r <= '0;
      sent_r    <= '0;
    end else if (cmd.step && (type_r == REQ_TICK)) begin
      running_r <= running_nxt;
      sent_r    <= sent_nxt;
    end
  end

  // memories: one write port at idx_r, registered read at rd_addr
  always_ff @(posedge clk) begin
    if (cmd.step && wr_st)   st_mem[idx_r]   <= st_new;
    if (cmd.step && wr_time) time_mem[idx_r] <= now_r;
    if (cmd.step && wr_chal) chal_mem[idx_r] <= chal_r;
    st_rd_r   <= st_mem[rd_addr];
    time_rd_r <= time_mem[rd_addr];
    chal_rd_r <= chal_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (cmd.step && wr_st) valid_r[idx_r] <= 1'b1;
      vld_rd_r <= valid_r[rd_addr];
    end
  end

  // result register
  logic out_valid_r;
  logic out_load;

  assign out_load = (cmd.step && need_out) || cmd.sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      out_kind    <= RK_SUMMARY;
      out_job     <= '0;
      out_rkind   <= RQ_CHALLENGE;
      out_chal    <= '0;
      out_phase   <= PH_IDLE;
      out_succ    <= 1'b0;
      out_running <= running_r;
      out_last    <= 1'b1;
    end else if (cmd.step && need_out) begin
      out_kind    <= res_kind;
      out_job     <= (type_r == REQ_TICK) ? JOB_W'(idx_r) : job_r;
      out_rkind   <= res_rkind;
      out_chal    <= res_chal;
      out_phase   <= res_phase;
      out_succ    <= res_succ;
      out_running <= '0;
      out_last    <= res_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.need_out  = need_out;
  assign sts.scan_done = scan_done;
  assign sts.is_tick   = (type_r == REQ_TICK);

endmodule
`default_nettype wire

[sv/challenge_query_retry_engine_core.sv]
// Query retry engine top level: controller plus datapath over the job tables.
// Start and packet items: accept with table read, then one update step.
// Tick items: accept, then one job per cycle (unless a send waits on the
// result register) through the table read and write ports, then the summary transaction.
// A full result register waits for out_tready; the scan stalls behind it.
// Reset: config to defaults, every job reads as done (per-job valid bits).
`timescale 1ns / 1ps
`default_nettype none
module challenge_query_retry_engine_core #(
  parameter int JOBS = cqre_pkg::JOBS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: job_index[4:0], now_ms[36:5], packet_length[49:37],
  //           packet_kind[57:50], packet_challenge[89:58], zero pad
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [cqre_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: req_type[1:0]
  input  wire logic [1:0]                          in_tuser,
  // out_tdata: out_job_index[4:0], request_kind[5], request_challenge[37:6],
  //            job_phase[40:38], job_success[41], running_jobs[47:42]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [cqre_pkg::OUT_DATA_W-1:0]          out_tdata,
  // out_tuser: result_kind[1:0]
  output logic [1:0]                               out_tuser,
  output logic                                     out_tlast,
  // config write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cqre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cqre_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cqre_pkg::*;

  cqre_cmd_t    cmd;
  cqre_sts_t    sts;
  req_type_t    in_type;
  result_kind_t out_kind;

  logic [JOB_W-1:0]  out_job;
  logic              out_rkind;
  logic [CHAL_W-1:0] out_chal;
  logic [PH_W-1:0]   out_phase;
  logic              out_succ;
  logic [CNT_W-1:0]  out_running;

  assign in_type   = req_type_t'(in_tuser);
  // Config registers always writable; user sends writes only while idle (unenforced).
  assign cfg_ready = 1'b1;

  cqre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_type   (in_type),
    .sts       (sts),
    .cmd       (cmd)
  );

  cqre_dp #(
    .JOBS (JOBS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_type     (in_type),
    .in_job      (in_tdata[4:0]),
    .in_now      (in_tdata[36:5]),
    .in_len      (in_tdata[49:37]),
    .in_kind     (in_tdata[57:50]),
    .in_chal     (in_tdata[89:58]),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_kind),
    .out_job     (out_job),
    .out_rkind   (out_rkind),
    .out_chal    (out_chal),
    .out_phase   (out_phase),
    .out_succ    (out_succ),
    .out_running (out_running),
    .out_last    (out_tlast)
  );

  assign out_tuser = out_kind;
  assign out_tdata = {out_running, out_succ, out_phase, out_chal, out_rkind, out_job};

endmodule
`default_nettype wire
